### design/tlsrd_pkg.sv
// shared types and constants of the tls record deframer
`timescale 1ns / 1ps
package tlsrd_pkg;

  // result status codes
  localparam logic [2:0] ST_HDR_BYTE   = 3'd0;
  localparam logic [2:0] ST_HDR_OK     = 3'd1;
  localparam logic [2:0] ST_HDR_REJECT = 3'd2;
  localparam logic [2:0] ST_PAYLOAD    = 3'd3;
  localparam logic [2:0] ST_DISCARD    = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_TYPE_MIN   = 2'd0;
  localparam logic [1:0] CFG_TYPE_MAX   = 2'd1;
  localparam logic [1:0] CFG_MAX_LENGTH = 2'd2;

  localparam logic [7:0]  TYPE_MIN_RESET   = 8'd20;
  localparam logic [7:0]  TYPE_MAX_RESET   = 8'd23;
  localparam logic [15:0] MAX_LENGTH_RESET = 16'd16384;

  localparam logic [7:0] TLS_MAJOR     = 8'd3;
  localparam logic [7:0] TLS_MINOR_MAX = 8'd3;
  // index of the last header byte (header is five bytes)
  localparam logic [2:0] HDR_LAST_IDX  = 3'd4;

  typedef struct packed {
    logic [7:0]  rec_type;
    logic [7:0]  major;
    logic [7:0]  minor;
    logic [15:0] length;
  } hdr_t;

  typedef struct packed {
    logic [7:0]  type_min;
    logic [7:0]  type_max;
    logic [15:0] max_length;
  } cfg_t;

endpackage

### design/tlsrd_if.sv
// stream interfaces for the byte input and the result output
`timescale 1ns / 1ps
interface tlsrd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface tlsrd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  payload_byte;
  logic [7:0]  record_type;
  logic [7:0]  version_major;
  logic [7:0]  version_minor;
  logic [15:0] record_length;
  logic        first_of_record;
  logic        last_of_record;

  modport source (
    output valid, output status, output payload_byte, output record_type,
    output version_major, output version_minor, output record_length,
    output first_of_record, output last_of_record, input ready
  );
  modport sink (
    input valid, input status, input payload_byte, input record_type,
    input version_major, input version_minor, input record_length,
    input first_of_record, input last_of_record, output ready
  );
endinterface

### design/tlsrd_hdr_check.sv
// record header validity check against the configured bounds
`timescale 1ns / 1ps
module tlsrd_hdr_check
  import tlsrd_pkg::*;
(
  input  hdr_t hdr,
  input  cfg_t cfg,
  output logic ok
);

  logic type_ok;
  logic version_ok;
  logic length_ok;

  always_comb begin
    type_ok    = (hdr.rec_type >= cfg.type_min) && (hdr.rec_type <= cfg.type_max);
    version_ok = (hdr.major == TLS_MAJOR) && (hdr.minor <= TLS_MINOR_MAX);
    length_ok  = (hdr.length != 16'd0) && (hdr.length <= cfg.max_length);
    ok         = type_ok && version_ok && length_ok;
  end

endmodule

### design/tls_record_deframer_core.sv
// top level of the tls record deframer: header parse, check and payload tagging
`timescale 1ns / 1ps
// each input transfer's result is registered in the output register, visible the cycle after the transfer
// throughput: one byte per cycle while the result side is ready; the header/payload state updates in the same
//   cycle the byte is taken, so only output back-pressure limits back-to-back transfers
// input ready stays high while the output register is empty or being drained
// reset (rst, synchronous, active high): header collection, counters cleared,
//   output register empty, configuration back to 20 / 23 / 16384
module tls_record_deframer_core
  import tlsrd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  tlsrd_in_if.sink     stream,
  tlsrd_out_if.source  result
);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_CORRUPT = 2'd2
  } phase_t;

  // configuration registers
  cfg_t cfg;

  // parse state
  phase_t      phase;
  logic [2:0]  header_index;
  logic [7:0]  held_type;
  logic [7:0]  held_major;
  logic [7:0]  held_minor;
  logic [7:0]  length_high;
  logic [15:0] held_length;
  logic [15:0] bytes_remaining;

  // output register
  logic        out_valid;
  logic [2:0]  out_status;
  logic [7:0]  out_payload;
  hdr_t        out_hdr;
  logic        out_first;
  logic        out_last;

  logic  in_fire;
  logic  hdr_ok;
  hdr_t  hdr_cur;
  logic  first_now;
  logic  last_now;
  logic  hdr_done;

  // take a byte whenever the result register is free or draining this cycle
  assign stream.ready = !out_valid || result.ready;
  assign in_fire      = stream.valid && stream.ready;

  // header as it stands once the fifth byte arrives
  assign hdr_cur = '{rec_type: held_type, major: held_major, minor: held_minor,
                     length: {length_high, stream.data_byte}};
  assign hdr_done = (header_index == HDR_LAST_IDX);

  tlsrd_hdr_check u_hdr_check (
    .hdr (hdr_cur),
    .cfg (cfg),
    .ok  (hdr_ok)
  );

  assign first_now = (bytes_remaining == held_length);
  assign last_now  = (bytes_remaining <= 16'd1);

  // configuration writes; an unused index is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.type_min   <= TYPE_MIN_RESET;
      cfg.type_max   <= TYPE_MAX_RESET;
      cfg.max_length <= MAX_LENGTH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TYPE_MIN:   cfg.type_min   <= cfg_data[7:0];
        CFG_TYPE_MAX:   cfg.type_max   <= cfg_data[7:0];
        CFG_MAX_LENGTH: cfg.max_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // parse state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      header_index    <= 3'd0;
      held_type       <= 8'd0;
      held_major      <= 8'd0;
      held_minor      <= 8'd0;
      length_high     <= 8'd0;
      held_length     <= 16'd0;
      bytes_remaining <= 16'd0;
      out_valid       <= 1'b0;
    end else begin
      if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (in_fire) begin
        out_valid   <= 1'b1;
        out_status  <= ST_DISCARD;
        out_payload <= 8'd0;
        out_hdr     <= '0;
        out_first   <= 1'b0;
        out_last    <= 1'b0;
        case (phase)
          PH_HEADER: begin
            case (header_index)
              3'd0: held_type   <= stream.data_byte;
              3'd1: held_major  <= stream.data_byte;
              3'd2: held_minor  <= stream.data_byte;
              3'd3: length_high <= stream.data_byte;
              default: ;
            endcase
            if (!hdr_done) begin
              header_index <= header_index + 3'd1;
              out_status   <= ST_HDR_BYTE;
            end else begin
              // fifth byte: header is complete, check it
              header_index <= 3'd0;
              held_length  <= hdr_cur.length;
              out_hdr      <= hdr_cur;
              if (hdr_ok) begin
                phase           <= PH_PAYLOAD;
                bytes_remaining <= hdr_cur.length;
                out_status      <= ST_HDR_OK;
              end else begin
                phase           <= PH_CORRUPT;
                bytes_remaining <= 16'd0;
                out_status      <= ST_HDR_REJECT;
              end
            end
          end
          PH_PAYLOAD: begin
            out_status  <= ST_PAYLOAD;
            out_payload <= stream.data_byte;
            out_hdr     <= '{rec_type: held_type, major: held_major,
                             minor: held_minor, length: held_length};
            out_first   <= first_now;
            out_last    <= last_now;
            if (last_now) begin
              bytes_remaining <= 16'd0;
              phase           <= PH_HEADER;
              header_index    <= 3'd0;
            end else begin
              bytes_remaining <= bytes_remaining - 16'd1;
            end
          end
          default: begin
            // corrupt stream: drop everything until reset
            phase <= PH_CORRUPT;
          end
        endcase
      end
    end
  end

  assign result.valid           = out_valid;
  assign result.status          = out_status;
  assign result.payload_byte    = out_payload;
  assign result.record_type     = out_hdr.rec_type;
  assign result.version_major   = out_hdr.major;
  assign result.version_minor   = out_hdr.minor;
  assign result.record_length   = out_hdr.length;
  assign result.first_of_record = out_first;
  assign result.last_of_record  = out_last;

`ifndef SYNTH
  // a discard result only appears once the stream has gone corrupt
  a_discard_corrupt: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status == ST_DISCARD) |-> (phase == PH_CORRUPT))
    else $error("discard result outside corrupt phase");

  // inside a record there is always at least one byte left
  a_payload_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD) |-> (bytes_remaining != 16'd0))
    else $error("payload phase with zero bytes remaining");

  // a rejected header locks the parser into the corrupt phase
  a_reject_locks: assert property (@(posedge clk) disable iff (rst)
    (in_fire && phase == PH_HEADER && hdr_done && !hdr_ok) |=> (phase == PH_CORRUPT))
    else $error("rejected header did not enter corrupt phase");

  // header index never runs past the last header byte
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    (header_index <= HDR_LAST_IDX))
    else $error("header index out of range");
`endif

endmodule
